FILE: sv/w210_pkg.sv
// ----------------------------------------------------------------------------
// w210_pkg: shared types, constants and the mod-210 wheel table
// Holds the item kinds, the queue entry layout and the 384-entry wheel.
// ----------------------------------------------------------------------------
package w210_pkg;

   localparam int SieveAddrBitsDefault = 15;
   localparam int WheelSize = 384;
   localparam int WheelSpokes = 48;
   localparam logic [3:0] Log2Min = 4'd10;
   localparam logic [3:0] Log2Max = 4'd15;
   localparam logic [3:0] Log2Reset = 4'd15;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_CROSS = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] clear_mask;
      logic [3:0] factor;
      logic [3:0] carry;
   } wheel_entry_type;

   // classified transaction passed from front to back
   typedef struct packed {
      kind_type        kind;
      logic            wheel_ok;
      logic [14:0]     addr;
      logic [7:0]      bval;
      logic [31:0]     prime;
      logic [8:0]      wheel;
      logic [8:0]      wheel_nx;
      wheel_entry_type ent;
      logic [3:0]      lg;
   } work_type;

   localparam logic [7:0] WT_MASK [WheelSize] = '{
      8'hfe,8'hf7,8'h7f,8'hbf,8'hfb,8'hfd,8'hdf,8'hfe,8'hef,8'hf7,8'h7f,8'hbf,8'hfd,8'hdf,
      8'hfe,8'hef,8'hf7,8'h7f,8'hfb,8'hfd,8'hdf,8'hef,8'hf7,8'h7f,8'hbf,8'hfb,8'hfd,8'hfe,
      8'hef,8'hf7,8'hbf,8'hfb,8'hfd,8'hdf,8'hfe,8'hef,8'h7f,8'hbf,8'hfb,8'hfd,8'hdf,8'hfe,
      8'hef,8'hf7,8'h7f,8'hbf,8'hfb,8'hdf,
      8'hfd,8'h7f,8'hdf,8'hfe,8'hbf,8'hfb,8'hef,8'hfd,8'hf7,8'h7f,8'hdf,8'hfe,8'hfb,8'hef,
      8'hfd,8'hf7,8'h7f,8'hdf,8'hbf,8'hfb,8'hef,8'hf7,8'h7f,8'hdf,8'hfe,8'hbf,8'hfb,8'hfd,
      8'hf7,8'h7f,8'hfe,8'hbf,8'hfb,8'hef,8'hfd,8'hf7,8'hdf,8'hfe,8'hbf,8'hfb,8'hef,8'hfd,
      8'hf7,8'h7f,8'hdf,8'hfe,8'hbf,8'hef,
      8'hfb,8'hdf,8'hef,8'hfd,8'hfe,8'hbf,8'hf7,8'hfb,8'h7f,8'hdf,8'hef,8'hfd,8'hbf,8'hf7,
      8'hfb,8'h7f,8'hdf,8'hef,8'hfe,8'hbf,8'hf7,8'h7f,8'hdf,8'hef,8'hfd,8'hfe,8'hbf,8'hfb,
      8'h7f,8'hdf,8'hfd,8'hfe,8'hbf,8'hf7,8'hfb,8'h7f,8'hef,8'hfd,8'hfe,8'hbf,8'hf7,8'hfb,
      8'h7f,8'hdf,8'hef,8'hfd,8'hfe,8'hf7,
      8'hf7,8'hfe,8'hfd,8'hef,8'hdf,8'h7f,8'hfb,8'hf7,8'hbf,8'hfe,8'hfd,8'hef,8'h7f,8'hfb,
      8'hf7,8'hbf,8'hfe,8'hfd,8'hdf,8'h7f,8'hfb,8'hbf,8'hfe,8'hfd,8'hef,8'hdf,8'h7f,8'hf7,
      8'hbf,8'hfe,8'hef,8'hdf,8'h7f,8'hfb,8'hf7,8'hbf,8'hfd,8'hef,8'hdf,8'h7f,8'hfb,8'hf7,
      8'hbf,8'hfe,8'hfd,8'hef,8'hdf,8'hfb,
      8'hef,8'hbf,8'hfe,8'hdf,8'h7f,8'hf7,8'hfd,8'hef,8'hfb,8'hbf,8'hfe,8'hdf,8'hf7,8'hfd,
      8'hef,8'hfb,8'hbf,8'hfe,8'h7f,8'hf7,8'hfd,8'hfb,8'hbf,8'hfe,8'hdf,8'h7f,8'hf7,8'hef,
      8'hfb,8'hbf,8'hdf,8'h7f,8'hf7,8'hfd,8'hef,8'hfb,8'hfe,8'hdf,8'h7f,8'hf7,8'hfd,8'hef,
      8'hfb,8'hbf,8'hfe,8'hdf,8'h7f,8'hfd,
      8'hdf,8'hfb,8'hbf,8'h7f,8'hf7,8'hef,8'hfe,8'hdf,8'hfd,8'hfb,8'hbf,8'h7f,8'hef,8'hfe,
      8'hdf,8'hfd,8'hfb,8'hbf,8'hf7,8'hef,8'hfe,8'hfd,8'hfb,8'hbf,8'h7f,8'hf7,8'hef,8'hdf,
      8'hfd,8'hfb,8'h7f,8'hf7,8'hef,8'hfe,8'hdf,8'hfd,8'hbf,8'h7f,8'hf7,8'hef,8'hfe,8'hdf,
      8'hfd,8'hfb,8'hbf,8'h7f,8'hf7,8'hfe,
      8'hbf,8'hef,8'hf7,8'hfb,8'hfd,8'hfe,8'h7f,8'hbf,8'hdf,8'hef,8'hf7,8'hfb,8'hfe,8'h7f,
      8'hbf,8'hdf,8'hef,8'hf7,8'hfd,8'hfe,8'h7f,8'hdf,8'hef,8'hf7,8'hfb,8'hfd,8'hfe,8'hbf,
      8'hdf,8'hef,8'hfb,8'hfd,8'hfe,8'h7f,8'hbf,8'hdf,8'hf7,8'hfb,8'hfd,8'hfe,8'h7f,8'hbf,
      8'hdf,8'hef,8'hf7,8'hfb,8'hfd,8'h7f,
      8'h7f,8'hfd,8'hfb,8'hf7,8'hef,8'hdf,8'hbf,8'h7f,8'hfe,8'hfd,8'hfb,8'hf7,8'hdf,8'hbf,
      8'h7f,8'hfe,8'hfd,8'hfb,8'hef,8'hdf,8'hbf,8'hfe,8'hfd,8'hfb,8'hf7,8'hef,8'hdf,8'h7f,
      8'hfe,8'hfd,8'hf7,8'hef,8'hdf,8'hbf,8'h7f,8'hfe,8'hfb,8'hf7,8'hef,8'hdf,8'hbf,8'h7f,
      8'hfe,8'hfd,8'hfb,8'hf7,8'hef,8'hbf
   };

   // factor and carry, packed as {factor, carry}
   localparam logic [7:0] WT_FC [WheelSize] = '{
      8'ha2,8'h20,8'h41,8'h21,8'h41,8'h61,8'h21,8'h61,8'h41,8'h20,8'h41,8'h62,8'h61,8'h21,
      8'h61,8'h41,8'h20,8'h62,8'h41,8'h61,8'h82,8'h41,8'h20,8'h41,8'h21,8'h41,8'h82,8'h61,
      8'h41,8'h61,8'h21,8'h41,8'h61,8'h21,8'h61,8'h61,8'h41,8'h21,8'h41,8'h61,8'h21,8'h61,
      8'h41,8'h20,8'h41,8'h21,8'ha2,8'h21,
      8'ha3,8'h21,8'h42,8'h20,8'h42,8'h62,8'h21,8'h62,8'h41,8'h21,8'h42,8'h62,8'h62,8'h21,
      8'h62,8'h41,8'h21,8'h62,8'h42,8'h62,8'h83,8'h41,8'h21,8'h42,8'h20,8'h42,8'h83,8'h62,
      8'h41,8'h63,8'h20,8'h42,8'h62,8'h21,8'h62,8'h62,8'h42,8'h20,8'h42,8'h62,8'h21,8'h62,
      8'h41,8'h21,8'h42,8'h20,8'ha4,8'h21,
      8'ha4,8'h21,8'h42,8'h21,8'h41,8'h63,8'h21,8'h62,8'h42,8'h21,8'h42,8'h62,8'h63,8'h21,
      8'h62,8'h42,8'h21,8'h63,8'h41,8'h63,8'h83,8'h42,8'h21,8'h42,8'h21,8'h41,8'h84,8'h62,
      8'h42,8'h63,8'h21,8'h41,8'h63,8'h21,8'h62,8'h63,8'h42,8'h21,8'h41,8'h63,8'h21,8'h62,
      8'h42,8'h21,8'h42,8'h21,8'ha4,8'h21,
      8'ha6,8'h21,8'h42,8'h21,8'h42,8'h64,8'h21,8'h63,8'h43,8'h21,8'h42,8'h63,8'h64,8'h21,
      8'h63,8'h43,8'h21,8'h63,8'h42,8'h64,8'h84,8'h43,8'h21,8'h42,8'h21,8'h42,8'h85,8'h63,
      8'h43,8'h63,8'h21,8'h42,8'h64,8'h21,8'h63,8'h64,8'h42,8'h21,8'h42,8'h64,8'h21,8'h63,
      8'h43,8'h21,8'h42,8'h21,8'ha6,8'h21,
      8'ha6,8'h22,8'h42,8'h21,8'h43,8'h64,8'h21,8'h64,8'h42,8'h22,8'h42,8'h64,8'h64,8'h21,
      8'h64,8'h42,8'h22,8'h63,8'h43,8'h64,8'h85,8'h42,8'h22,8'h42,8'h21,8'h43,8'h85,8'h64,
      8'h42,8'h64,8'h21,8'h43,8'h64,8'h21,8'h64,8'h64,8'h42,8'h21,8'h43,8'h64,8'h21,8'h64,
      8'h42,8'h22,8'h42,8'h21,8'ha7,8'h21,
      8'ha8,8'h21,8'h43,8'h22,8'h43,8'h65,8'h21,8'h65,8'h43,8'h21,8'h43,8'h65,8'h65,8'h21,
      8'h65,8'h43,8'h21,8'h65,8'h43,8'h65,8'h86,8'h43,8'h21,8'h43,8'h22,8'h43,8'h86,8'h65,
      8'h43,8'h64,8'h22,8'h43,8'h65,8'h21,8'h65,8'h64,8'h43,8'h22,8'h43,8'h65,8'h21,8'h65,
      8'h43,8'h21,8'h43,8'h22,8'ha8,8'h21,
      8'haa,8'h22,8'h44,8'h22,8'h44,8'h65,8'h22,8'h66,8'h44,8'h22,8'h44,8'h66,8'h65,8'h22,
      8'h66,8'h44,8'h22,8'h66,8'h44,8'h65,8'h88,8'h44,8'h22,8'h44,8'h22,8'h44,8'h87,8'h66,
      8'h44,8'h66,8'h22,8'h44,8'h65,8'h22,8'h66,8'h66,8'h44,8'h22,8'h44,8'h65,8'h22,8'h66,
      8'h44,8'h22,8'h44,8'h22,8'ha9,8'h22,
      8'ha1,8'h20,8'h40,8'h20,8'h40,8'h60,8'h20,8'h61,8'h40,8'h20,8'h40,8'h60,8'h60,8'h20,
      8'h61,8'h40,8'h20,8'h60,8'h40,8'h60,8'h81,8'h40,8'h20,8'h40,8'h20,8'h40,8'h80,8'h61,
      8'h40,8'h60,8'h20,8'h40,8'h60,8'h20,8'h61,8'h60,8'h40,8'h20,8'h40,8'h60,8'h20,8'h61,
      8'h40,8'h20,8'h40,8'h20,8'ha0,8'h20
   };

   function automatic wheel_entry_type wheel_lookup(input logic [8:0] w);
      wheel_entry_type e;
      e.clear_mask = WT_MASK[w];
      e.factor     = WT_FC[w][7:4];
      e.carry      = WT_FC[w][3:0];
      return e;
   endfunction

endpackage

FILE: sv/w210_front.sv
// ----------------------------------------------------------------------------
// w210_front: input stage
// Accepts transactions, masks indices, looks up the wheel and advances it.
// ----------------------------------------------------------------------------
module w210_front #(
   parameter int SIEVE_ADDR_BITS = w210_pkg::SieveAddrBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           seg_log2,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0]           in_kind,
   input  logic [14:0]          in_addr,
   input  logic [7:0]           in_bval,
   input  logic [31:0]          in_prime,
   input  logic [14:0]          in_midx,
   input  logic [8:0]           in_wheel,
   output logic                 out_valid,
   input  logic                 out_ready,
   output w210_pkg::work_type   out_work
);
   import w210_pkg::*;

   localparam logic [3:0] HiLog2 =
      (SIEVE_ADDR_BITS < 15) ? 4'(SIEVE_ADDR_BITS) : Log2Max;

   logic     valid_ff, valid_in;
   work_type work_ff, work_in;
   logic [3:0]  lg;
   logic [14:0] mask, pick;
   logic        last_spoke;

   // effective segment size
   always_comb begin
      lg = seg_log2;
      if (lg < Log2Min) lg = Log2Min;
      if (lg > HiLog2) lg = HiLog2;
      mask = 15'((16'd1 << lg) - 16'd1);
   end

   assign in_ready = !valid_ff || out_ready;

   // classify
   always_comb begin
      pick = (in_kind == KIND_CROSS) ? in_midx : in_addr;
      // last spoke of each residue class wraps back to the class start
      last_spoke = 1'b0;
      for (int c = 1; c <= WheelSize / WheelSpokes; c++) begin
         if (in_wheel == 9'(c * WheelSpokes - 1)) last_spoke = 1'b1;
      end
      work_in.kind     = kind_type'(in_kind);
      work_in.addr     = pick & mask;
      work_in.bval     = in_bval;
      work_in.prime    = in_prime;
      work_in.wheel    = in_wheel;
      work_in.wheel_ok = (in_wheel < 9'(WheelSize));
      work_in.ent      = wheel_lookup(work_in.wheel_ok ? in_wheel : 9'd0);
      work_in.wheel_nx = last_spoke ? in_wheel - 9'(WheelSpokes - 1) : in_wheel + 9'd1;
      work_in.lg       = lg;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (in_ready && in_valid) work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;
endmodule

FILE: sv/w210_queue.sv
// ----------------------------------------------------------------------------
// w210_queue: two-entry queue
// Decouples the front stage from the store stage.
// ----------------------------------------------------------------------------
module w210_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  w210_pkg::work_type   in_work,
   output logic                 out_valid,
   input  logic                 out_ready,
   output w210_pkg::work_type   out_work
);
   import w210_pkg::*;

   work_type   slot_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_work  = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // pointers and fill count
   always_comb begin
      rd_in  = pop ? !rd_ff : rd_ff;
      wr_in  = push ? !wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= in_work;
   end
endmodule

FILE: sv/w210_back.sv
// ----------------------------------------------------------------------------
// w210_back: store and step stage
// Reads and writes the sieve store, computes the next multiple, holds result.
// ----------------------------------------------------------------------------
module w210_back #(
   parameter int SIEVE_ADDR_BITS = w210_pkg::SieveAddrBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  w210_pkg::work_type   in_work,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_read_byte,
   output logic [31:0]          out_prime,
   output logic [14:0]          out_next_index,
   output logic [8:0]           out_next_wheel,
   output logic [25:0]          out_segments_ahead
);
   import w210_pkg::*;

   localparam int AW = (SIEVE_ADDR_BITS < 15) ? SIEVE_ADDR_BITS : 15;
   localparam int Depth = 1 << AW;

   logic [7:0] store [Depth];

   // stage 1: registered memory read, product
   logic        s1_valid_ff;
   work_type    s1_work_ff;
   logic [7:0]  s1_rd_ff;
   logic [35:0] s1_prod_ff;
   // stage 2: result register
   logic        s2_valid_ff;
   logic [7:0]  s2_byte_ff;
   logic [31:0] s2_prime_ff;
   logic [14:0] s2_idx_ff;
   logic [8:0]  s2_wheel_ff;
   logic [25:0] s2_seg_ff;

   logic        s1_adv, s2_adv, acc;
   logic        wr_en, fwd;
   logic [7:0]  wr_data, cur_byte;
   logic [36:0] next_sum;
   logic [14:0] seg_mask, nidx;
   logic [25:0] nseg;
   logic [AW-1:0] rd_a, wr_a;

   assign s2_adv   = !s2_valid_ff || out_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;
   assign acc      = in_valid && s1_adv;
   assign rd_a     = in_work.addr[AW-1:0];
   assign wr_a     = s1_work_ff.addr[AW-1:0];

   // byte of the item in stage 1, forwarded from the write in flight
   assign fwd      = wr_en && (rd_a == wr_a);
   assign cur_byte = s1_rd_ff;

   // store write for load and cross-off
   always_comb begin
      wr_en   = 1'b0;
      wr_data = s1_work_ff.bval;
      if (s1_valid_ff && s2_adv) begin
         if (s1_work_ff.kind == KIND_LOAD) wr_en = 1'b1;
         if (s1_work_ff.kind == KIND_CROSS && s1_work_ff.wheel_ok) begin
            wr_en   = 1'b1;
            wr_data = cur_byte & s1_work_ff.ent.clear_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) store[wr_a] <= wr_data;
      if (acc) begin
         s1_rd_ff   <= fwd ? wr_data : store[rd_a];
         s1_work_ff <= in_work;
         s1_prod_ff <= in_work.prime * in_work.ent.factor;
      end else if (wr_en && s1_valid_ff) begin
         s1_rd_ff <= s1_rd_ff;
      end
   end

   // next multiple
   always_comb begin
      seg_mask = 15'((16'd1 << s1_work_ff.lg) - 16'd1);
      next_sum = 37'(s1_work_ff.addr) + 37'(s1_prod_ff) + 37'(s1_work_ff.ent.carry);
      nidx     = next_sum[14:0] & seg_mask;
      nseg     = 26'(next_sum >> s1_work_ff.lg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= in_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
      end
      if (s2_adv && s1_valid_ff) begin
         s2_byte_ff  <= '0;
         s2_prime_ff <= '0;
         s2_idx_ff   <= '0;
         s2_wheel_ff <= '0;
         s2_seg_ff   <= '0;
         case (s1_work_ff.kind)
            KIND_READ: s2_byte_ff <= cur_byte;
            KIND_CROSS: begin
               s2_prime_ff <= s1_work_ff.prime;
               if (s1_work_ff.wheel_ok) begin
                  s2_idx_ff   <= nidx;
                  s2_wheel_ff <= s1_work_ff.wheel_nx;
                  s2_seg_ff   <= nseg;
               end else begin
                  s2_idx_ff   <= s1_work_ff.addr;
                  s2_wheel_ff <= s1_work_ff.wheel;
               end
            end
            default: ;
         endcase
      end
   end

   assign out_valid          = s2_valid_ff;
   assign out_read_byte      = s2_byte_ff;
   assign out_prime          = s2_prime_ff;
   assign out_next_index     = s2_idx_ff;
   assign out_next_wheel     = s2_wheel_ff;
   assign out_segments_ahead = s2_seg_ff;
endmodule

FILE: sv/wheel210_bucket_sieve_crossoff.sv
// ----------------------------------------------------------------------------
// wheel210_bucket_sieve_crossoff: sieve segment cross-off unit
// Byte store of one segment; crosses off one record per transaction.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  req_     | in  | kind, byte address/value, sieving record
//  rsp_     | out | read byte, requeue record, segments ahead
//  csr_     | in  | segment_log2 at address 0
// One transaction per cycle sustained while rsp_ does not stall; the path is
// input register, queue, store read with forwarding of the byte written in
// the same cycle, result register. The single store port pair limits it to
// one read-modify-write per cycle. Reset clears control state only; the store
// holds garbage until loaded. Either side may stall independently.
// ----------------------------------------------------------------------------
module wheel210_bucket_sieve_crossoff #(
   parameter int SIEVE_ADDR_BITS = w210_pkg::SieveAddrBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kind[1:0]
   input  logic [1:0]   req_tuser,
   // byte_address[14:0], byte_value[22:15], sieving_prime[54:23],
   // multiple_index[69:55], wheel_index[78:70]
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_byte[7:0], prime_out[39:8], next_index[54:40], next_wheel[63:55],
   // segments_ahead[89:64]
   output logic [95:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import w210_pkg::*;

   localparam logic [2:0] RegSegLog2 = 3'd0;

   logic [3:0] seg_ff;
   logic       f_valid, f_ready, q_valid, q_ready;
   work_type   f_work, q_work;
   logic [7:0]  rb;
   logic [31:0] pr;
   logic [14:0] ni;
   logic [8:0]  nw;
   logic [25:0] sa;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegSegLog2) ? {28'd0, seg_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) seg_ff <= Log2Reset;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == RegSegLog2)
         seg_ff <= csr_pwdata[3:0];
   end

   w210_front #(.SIEVE_ADDR_BITS(SIEVE_ADDR_BITS)) u_front (
      .clock, .reset, .seg_log2(seg_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_kind(req_tuser), .in_addr(req_tdata[14:0]), .in_bval(req_tdata[22:15]),
      .in_prime(req_tdata[54:23]), .in_midx(req_tdata[69:55]),
      .in_wheel(req_tdata[78:70]),
      .out_valid(f_valid), .out_ready(f_ready), .out_work(f_work)
   );

   w210_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_work(f_work),
      .out_valid(q_valid), .out_ready(q_ready), .out_work(q_work)
   );

   w210_back #(.SIEVE_ADDR_BITS(SIEVE_ADDR_BITS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_work(q_work),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_read_byte(rb), .out_prime(pr), .out_next_index(ni),
      .out_next_wheel(nw), .out_segments_ahead(sa)
   );

   assign rsp_tdata = {6'd0, sa, nw, ni, pr, rb};
endmodule
